### design/lkc_pkg.sv
// ----------------------------------------------------------------------------
// LRU key cache package
// Shared types and constants for the fully associative LRU key cache.
// ----------------------------------------------------------------------------
package lkc_pkg;

   // Width of the capacity register and its value after reset.
   localparam int CAP_W = 7;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Width of the operation code of an item.
   localparam int KIND_W = 2;

   // Operation codes. The unused code behaves as a lookup.
   typedef enum logic [KIND_W-1:0] {
      KIND_ACCESS = 2'd0,
      KIND_LOOKUP = 2'd1,
      KIND_REMOVE = 2'd2
   } lkc_kind_type;

   // Command broadcast from the control logic to every entry cell.
   typedef struct packed {
      logic touch;   // access hit: matched entry becomes most recent
      logic drop;    // remove hit: matched entry is deleted
      logic insert;  // access miss: new key goes into the fill slot
      logic evict;   // access miss at capacity: oldest entry is dropped
   } lkc_cmd_type;

endpackage

### design/lkc_entry.sv
// ----------------------------------------------------------------------------
// LRU key cache entry cell
// One slot of the cache: key, valid bit and recency rank, with the key
// compare and the rank update for every command.
// ----------------------------------------------------------------------------
module lkc_entry #(
   parameter int KEY_BITS = 64,
   parameter int RANK_W   = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lkc_pkg::lkc_cmd_type  cmd,
   input  logic [KEY_BITS-1:0]   key,
   input  logic [RANK_W-1:0]     ref_rank,
   input  logic [RANK_W-1:0]     last_rank,
   input  logic                  fill_sel,
   output logic                  match,
   output logic                  oldest,
   output logic                  valid,
   output logic [RANK_W-1:0]     rank,
   output logic [KEY_BITS-1:0]   key_out
);
   import lkc_pkg::*;

   logic                valid_ff, valid_in;
   logic [RANK_W-1:0]   rank_ff, rank_in;
   logic [KEY_BITS-1:0] key_ff, key_in;

   // Compare and age flags seen by the control logic.
   assign match   = valid_ff && (key_ff == key);
   assign oldest  = valid_ff && (rank_ff == last_rank);
   assign valid   = valid_ff;
   assign rank    = rank_ff;
   assign key_out = key_ff;

   // Next state of this slot for the command in flight.
   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      key_in   = key_ff;
      if (cmd.touch) begin
         if (match) begin
            rank_in = '0;
         end else if (valid_ff && (rank_ff < ref_rank)) begin
            rank_in = rank_ff + 1'b1;
         end
      end
      if (cmd.drop) begin
         if (match) begin
            valid_in = 1'b0;
            rank_in  = '0;
         end else if (valid_ff && (rank_ff > ref_rank)) begin
            rank_in = rank_ff - 1'b1;
         end
      end
      if (cmd.insert) begin
         if (cmd.evict && oldest) begin
            valid_in = 1'b0;
            rank_in  = '0;
         end else if (valid_ff) begin
            rank_in = rank_ff + 1'b1;
         end
         if (fill_sel) begin
            valid_in = 1'b1;
            rank_in  = '0;
            key_in   = key;
         end
      end
   end

   // Control state of the slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   // Key storage; only read while the slot is valid.
   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

### design/lru_key_cache_policy.sv
// ----------------------------------------------------------------------------
// LRU key cache policy
// Fully associative store of keys with least recently used replacement.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle and never raises busy. Each
// item is held in an input register; in the next cycle every entry cell
// compares its key in parallel and updates its recency rank, and the result
// appears on the rsp_ ports in the cycle after that. The rsp_strobe pulse
// lasts one cycle and the receiver must take the item then. The capacity
// register may be written at any time that no item is in flight; csr_ready
// is always high.
module lru_key_cache_policy #(
   parameter int ENTRIES  = 64,
   parameter int KEY_BITS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [lkc_pkg::KIND_W-1:0]          req_kind,
   input  logic [KEY_BITS-1:0]                 req_key,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lkc_pkg::CAP_W-1:0]           csr_wdata,
   output logic                                rsp_strobe,
   output logic                                rsp_hit,
   output logic                                rsp_evicted,
   output logic [KEY_BITS-1:0]                 rsp_victim_key,
   output logic [$clog2(ENTRIES+1)-1:0]        rsp_occupancy
);
   import lkc_pkg::*;

   localparam int RANK_W = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // Input register.
   logic                 req_valid_ff;
   logic [KIND_W-1:0]    req_kind_ff;
   logic [KEY_BITS-1:0]  req_key_ff;

   // Configuration and occupancy.
   logic [CAP_W-1:0]     cap_ff;
   logic [CNT_W-1:0]     count_ff, count_in;

   // Result register.
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic                 rsp_evicted_ff, rsp_evicted_in;
   logic [KEY_BITS-1:0]  rsp_victim_key_ff, rsp_victim_key_in;

   // Cell interface.
   lkc_cmd_type          cmd;
   logic [ENTRIES-1:0]   cell_match;
   logic [ENTRIES-1:0]   cell_oldest;
   logic [ENTRIES-1:0]   cell_valid;
   logic [ENTRIES-1:0]   valid_post;
   logic [ENTRIES-1:0]   free_vec;
   logic [ENTRIES-1:0]   fill_vec;
   logic [RANK_W-1:0]    cell_rank [ENTRIES];
   logic [KEY_BITS-1:0]  cell_key  [ENTRIES];
   logic [RANK_W-1:0]    hit_rank;
   logic [RANK_W-1:0]    last_rank;
   logic [KEY_BITS-1:0]  oldest_key;
   logic                 hit;
   logic                 at_limit;
   logic [CMP_W-1:0]     cap_ext;
   logic [CNT_W-1:0]     limit;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Capture an item; a new one may come every cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_kind_ff <= req_kind;
         req_key_ff  <= req_key;
      end
   end

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_wdata;
      end
   end

   // Effective limit: zero counts as one, and the entry count caps it.
   always_comb begin
      cap_ext = CMP_W'(cap_ff);
      if (cap_ext == '0) begin
         limit = CNT_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         limit = CNT_W'(ENTRIES);
      end else begin
         limit = CNT_W'(cap_ext);
      end
   end

   // Ranks of valid entries run from zero to count minus one.
   assign last_rank = RANK_W'(count_ff - 1'b1);

   // Gather the hit rank and the oldest key from the cells.
   always_comb begin
      hit_rank   = '0;
      oldest_key = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_rank   = hit_rank   | (cell_match[i]  ? cell_rank[i] : '0);
         oldest_key = oldest_key | (cell_oldest[i] ? cell_key[i]  : '0);
      end
   end

   assign hit      = |cell_match;
   assign at_limit = (count_ff >= limit);

   // Decide the command for the item in the input register.
   always_comb begin
      cmd               = '0;
      count_in          = count_ff;
      rsp_hit_in        = hit;
      rsp_evicted_in    = 1'b0;
      rsp_victim_key_in = '0;
      if (req_valid_ff) begin
         case (req_kind_ff)
            KIND_ACCESS: begin
               if (hit) begin
                  cmd.touch = 1'b1;
               end else begin
                  cmd.insert = 1'b1;
                  cmd.evict  = at_limit;
                  if (at_limit) begin
                     rsp_evicted_in    = 1'b1;
                     rsp_victim_key_in = oldest_key;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end
            end
            KIND_REMOVE: begin
               if (hit) begin
                  cmd.drop = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               cmd = '0;
            end
         endcase
      end
   end

   // The new key goes into the lowest free slot left after any eviction.
   assign valid_post = cell_valid & ~(cell_oldest & {ENTRIES{cmd.evict}});
   assign free_vec   = ~valid_post;
   assign fill_vec   = free_vec & (~free_vec + 1'b1);

   // Entry cells.
   for (genvar g = 0; g < ENTRIES; g++) begin : g_entry
      lkc_entry #(
         .KEY_BITS (KEY_BITS),
         .RANK_W   (RANK_W)
      ) u_entry (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .key       (req_key_ff),
         .ref_rank  (hit_rank),
         .last_rank (last_rank),
         .fill_sel  (fill_vec[g]),
         .match     (cell_match[g]),
         .oldest    (cell_oldest[g]),
         .valid     (cell_valid[g]),
         .rank      (cell_rank[g]),
         .key_out   (cell_key[g])
      );
   end

   // Occupancy counter and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      rsp_hit_ff        <= rsp_hit_in;
      rsp_evicted_ff    <= rsp_evicted_in;
      rsp_victim_key_ff <= rsp_victim_key_in;
   end

   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_evicted    = rsp_evicted_ff;
   assign rsp_victim_key = rsp_victim_key_ff;
   assign rsp_occupancy  = count_ff;

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU key cache policy testbench
// Drives access, lookup and remove items into the LRU key cache under a range
// of capacities. A tracker keeps its own copy of the store and checks every
// result field against its prediction.
// ----------------------------------------------------------------------------

module testbench;
   import lkc_pkg::*;

   localparam int SLOTS = 64;
   localparam int KEY_W = 64;
   localparam int OCC_W = 7;

   // The unused operation code; the block treats it as a lookup.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic             hit;
      logic             evicted;
      logic [KEY_W-1:0] victim_key;
      logic [OCC_W-1:0] occupancy;
   } lru_outcome_type;

   // Keeps a shadow of the LRU store and the queue of results still to come.
   class lru_tracker_type;
      logic [KEY_W-1:0] slot_key [SLOTS];
      bit               slot_valid [SLOTS];
      int unsigned      slot_age [SLOTS];
      int unsigned      live;
      logic [CAP_W-1:0] cap_reg;
      lru_outcome_type  outcome_q [$];
      int unsigned      errors;
      int unsigned      checked;
      int unsigned      hits;
      int unsigned      evictions;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_age[i] = 0;
            slot_key[i] = '0;
         end
         live = 0;
         cap_reg = CAP_RESET;
         errors = 0;
         checked = 0;
         hits = 0;
         evictions = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] value);
         cap_reg = value;
      endfunction

      function int unsigned pending();
         return outcome_q.size();
      endfunction

      // Zero counts as one, and anything past the store size is clipped.
      function int unsigned entry_limit();
         if (cap_reg == 0) return 1;
         if (cap_reg > SLOTS) return SLOTS;
         return 32'(cap_reg);
      endfunction

      // Make slot s the most recent; the entries newer than it age by one.
      function void promote(int s);
         int unsigned r;
         r = slot_age[s];
         for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_age[i] < r) slot_age[i]++;
         slot_age[s] = 0;
      endfunction

      // Delete slot s; the entries older than it move one step up.
      function void retire(int s);
         int unsigned r;
         r = slot_age[s];
         slot_valid[s] = 1'b0;
         slot_age[s] = 0;
         for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_age[i] > r) slot_age[i]--;
         if (live > 0) live--;
      endfunction

      function int oldest();
         int best;
         best = -1;
         for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && (best < 0 || slot_age[i] > slot_age[best])) best = i;
         return best;
      endfunction

      // Apply one accepted item to the shadow store and queue its result.
      function void note_item(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key);
         int              s;
         int              o;
         bit              placed;
         lru_outcome_type res;
         s = -1;
         placed = 1'b0;
         res = '0;
         for (int i = 0; i < SLOTS; i++)
            if (s < 0 && slot_valid[i] && slot_key[i] == key) s = i;
         res.hit = (s >= 0);
         if (kind == KIND_ACCESS) begin
            if (s >= 0) begin
               promote(s);
            end else begin
               // A miss evicts one entry when the store would exceed its limit.
               if (live + 1 > entry_limit() || live >= SLOTS) begin
                  o = oldest();
                  if (o >= 0) begin
                     res.evicted = 1'b1;
                     res.victim_key = slot_key[o];
                     retire(o);
                  end
               end
               for (int i = 0; i < SLOTS; i++) begin
                  if (!placed && !slot_valid[i]) begin
                     for (int j = 0; j < SLOTS; j++)
                        if (slot_valid[j]) slot_age[j]++;
                     slot_valid[i] = 1'b1;
                     slot_key[i] = key;
                     slot_age[i] = 0;
                     live++;
                     placed = 1'b1;
                  end
               end
            end
         end else if (kind == KIND_REMOVE && s >= 0) begin
            retire(s);
         end
         res.occupancy = live[OCC_W-1:0];
         outcome_q.push_back(res);
      endfunction

      function void report(string field, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            errors++;
         end
      endfunction

      // Compare one result from the block with the oldest prediction.
      function void check_result(logic hit, logic evicted, logic [KEY_W-1:0] victim_key,
                                 logic [OCC_W-1:0] occupancy);
         lru_outcome_type want;
         if (outcome_q.size() == 0) begin
            $display("%0t: unexpected result, expected none actual hit=%b occupancy=%0d",
                     $time, hit, occupancy);
            errors++;
            return;
         end
         want = outcome_q.pop_front();
         checked++;
         if (want.hit) hits++;
         if (want.evicted) evictions++;
         report("hit", KEY_W'(want.hit), KEY_W'(hit));
         report("evicted", KEY_W'(want.evicted), KEY_W'(evicted));
         report("victim_key", want.victim_key, victim_key);
         report("occupancy", KEY_W'(want.occupancy), KEY_W'(occupancy));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [KIND_W-1:0]   req_kind;
   logic [KEY_W-1:0]    req_key;
   logic                csr_valid;
   logic                csr_ready;
   logic [CAP_W-1:0]    csr_wdata;
   logic                rsp_strobe;
   logic                rsp_hit;
   logic                rsp_evicted;
   logic [KEY_W-1:0]    rsp_victim_key;
   logic [OCC_W-1:0]    rsp_occupancy;

   lru_tracker_type     tracker;
   logic [KEY_W-1:0]    key_pool [128];
   int unsigned         items_sent;

   lru_key_cache_policy #(
      .ENTRIES  (SLOTS),
      .KEY_BITS (KEY_W)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_key        (req_key),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .rsp_strobe     (rsp_strobe),
      .rsp_hit        (rsp_hit),
      .rsp_evicted    (rsp_evicted),
      .rsp_victim_key (rsp_victim_key),
      .rsp_occupancy  (rsp_occupancy)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every strobed result is taken at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         tracker.check_result(rsp_hit, rsp_evicted, rsp_victim_key, rsp_occupancy);
   end

   // Present one item and hold it until the block takes it.
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
      req_kind <= kind;
      req_key <= key;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      tracker.note_item(kind, key);
      items_sent++;
   endtask

   // Stop sending and wait for every outstanding result.
   task automatic wait_all_results();
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // Capacity changes only while the block is idle.
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      wait_all_results();
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.set_capacity(value);
   endtask

   // With the given chance in percent, go quiet for a burst of cycles.
   task automatic maybe_idle(input int unsigned pct);
      if ($urandom_range(99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // Mostly keys from a small working set so hits and evictions are common.
   function automatic logic [KEY_W-1:0] pick_key(input int unsigned span);
      if ($urandom_range(15) == 0) return {$urandom, $urandom};
      return key_pool[$urandom_range(span - 1)];
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60) return KIND_ACCESS;
      if (roll < 80) return KIND_LOOKUP;
      if (roll < 96) return KIND_REMOVE;
      return KIND_UNUSED;
   endfunction

   // Run guard.
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      logic [CAP_W-1:0] cap_plan [9];
      int unsigned      count_plan [9];
      int unsigned      span_plan [9];
      int unsigned      idle_plan [9];

      cap_plan   = '{7'd127, 7'd1, 7'd0, 7'd5, 7'd64, 7'd6, 7'd17, 7'd0, 7'd40};
      count_plan = '{160, 110, 110, 130, 170, 130, 130, 130, 120};
      span_plan  = '{90, 4, 3, 10, 80, 12, 30, 0, 50};
      idle_plan  = '{25, 30, 0, 40, 20, 15, 35, 25, 0};
      cap_plan[7] = 7'($urandom_range(2, 63));
      span_plan[7] = 32'(cap_plan[7]) + 32'(cap_plan[7]) / 2 + 2;

      tracker = new();
      items_sent = 0;
      for (int i = 0; i < 128; i++) key_pool[i] = {$urandom, $urandom};

      reset <= 1'b1;
      start <= 1'b0;
      req_kind <= KIND_ACCESS;
      req_key <= '0;
      csr_valid <= 1'b0;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a tiny store to show refresh, eviction and the odd cases.
      write_capacity(7'd2);
      send_item(KIND_LOOKUP, '0);           // lookup in an empty store
      send_item(KIND_REMOVE, '1);           // remove of an absent key
      send_item(KIND_ACCESS, '0);
      send_item(KIND_ACCESS, '1);
      send_item(KIND_ACCESS, '0);           // hit makes zero the newest
      send_item(KIND_ACCESS, key_pool[2]);  // evicts the all-ones key
      send_item(KIND_UNUSED, key_pool[2]);  // unused code acts as a lookup
      send_item(KIND_LOOKUP, '1);
      send_item(KIND_REMOVE, '0);
      send_item(KIND_REMOVE, '0);           // already gone
      send_item(KIND_ACCESS, '1);
      send_item(KIND_ACCESS, key_pool[3]);
      write_capacity(7'd0);                 // zero behaves as one
      send_item(KIND_ACCESS, key_pool[4]);  // store stays above the limit
      send_item(KIND_ACCESS, key_pool[3]);
      send_item(KIND_ACCESS, key_pool[5]);
      send_item(KIND_REMOVE, key_pool[5]);
      write_capacity(7'd127);               // clipped to the store size
      for (int i = 0; i < 6; i++) send_item(KIND_ACCESS, key_pool[i]);
      send_item(KIND_LOOKUP, key_pool[0]);

      // Random phases, each under its own capacity.
      for (int p = 0; p < 9; p++) begin
         write_capacity(cap_plan[p]);
         for (int n = 0; n < count_plan[p]; n++) begin
            send_item(pick_kind(), pick_key(span_plan[p]));
            if (p == 4 && n == count_plan[p] / 2) wait_all_results();
            else maybe_idle(idle_plan[p]);
         end
      end

      wait_all_results();
      repeat (10) @(posedge clock);
      $display("Ran %0d items across twelve capacity writes, from zero up past the store size.",
               items_sent);
      $display("Checked %0d results: %0d hits and %0d evictions.",
               tracker.checked, tracker.hits, tracker.evictions);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### lru_key_cache_policy.f
design/lkc_pkg.sv
design/lkc_entry.sv
design/lru_key_cache_policy.sv
bench/testbench.sv
